FILE: rtl/id3_pkg.sv
// Package: shared types, codes and lookup functions of the ID3 tag frame extractor.
`default_nettype none

package id3_pkg;

   // Tag signature and the frame IDs of interest
   localparam logic [23:0] ID3_SIGNATURE = 24'h494433;
   localparam logic [31:0] ID_TITLE      = 32'h54495432;
   localparam logic [31:0] ID_YEAR       = 32'h54594552;
   localparam logic [31:0] ID_ALBUM      = 32'h54414C42;
   localparam logic [31:0] ID_ARTIST     = 32'h54504531;
   localparam logic [31:0] ID_BPM        = 32'h5442504D;

   localparam int unsigned SELECT_WIDTH  = 5;
   localparam logic [SELECT_WIDTH-1:0] SELECT_RESET = 5'h1F;

   // Header byte positions and frame header byte positions
   localparam logic [3:0] HDR_VERSION_MAJOR = 4'd3;
   localparam logic [3:0] HDR_VERSION_REV   = 4'd4;
   localparam logic [3:0] HDR_FLAGS         = 4'd5;
   localparam logic [3:0] HDR_LAST          = 4'd9;
   localparam logic [3:0] FHDR_ID_END       = 4'd4;
   localparam logic [3:0] FHDR_SIZE_END     = 4'd8;
   localparam logic [3:0] FHDR_LEN          = 4'd10;
   localparam logic [3:0] FHDR_IN_PAYLOAD   = 4'd11;
   localparam int unsigned EXT_HEADER_BIT   = 6;

   // Frame kinds
   typedef enum logic [2:0] {
      KIND_TITLE  = 3'd0,
      KIND_YEAR   = 3'd1,
      KIND_ALBUM  = 3'd2,
      KIND_ARTIST = 3'd3,
      KIND_BPM    = 3'd4,
      KIND_NONE   = 3'd5
   } kind_type;

   // Reported status
   typedef enum logic [1:0] {
      ST_PARSING = 2'd0,
      ST_NO_ID3  = 2'd1,
      ST_DONE    = 2'd2,
      ST_ERROR   = 2'd3
   } status_type;

   // Parser phases
   typedef enum logic [2:0] {
      PH_HEADER    = 3'd0,
      PH_FRAME_HDR = 3'd1,
      PH_PAYLOAD   = 3'd2,
      PH_NO_ID3    = 3'd3,
      PH_TAG_DONE  = 3'd4,
      PH_ERROR     = 3'd5
   } phase_type;

   // One result item
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_valid;
      kind_type    frame_kind;
      logic        frame_end;
      logic [15:0] tag_version;
      status_type  status;
   } rsp_payload_type;

   // Expected signature byte at header position idx
   function automatic logic [7:0] sig_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = ID3_SIGNATURE[23:16];
         2'd1:    b = ID3_SIGNATURE[15:8];
         2'd2:    b = ID3_SIGNATURE[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Map a frame ID to its kind
   function automatic kind_type kind_of(input logic [31:0] id);
      kind_type k;
      if (id == ID_TITLE)       k = KIND_TITLE;
      else if (id == ID_YEAR)   k = KIND_YEAR;
      else if (id == ID_ALBUM)  k = KIND_ALBUM;
      else if (id == ID_ARTIST) k = KIND_ARTIST;
      else if (id == ID_BPM)    k = KIND_BPM;
      else                      k = KIND_NONE;
      return k;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/id3_req_if.sv
// Interface: input byte channel with valid/ready handshake.
`default_nettype none

interface id3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/id3_rsp_if.sv
// Interface: result channel with valid/ready handshake.
`default_nettype none

interface id3_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        out_valid;
   logic [2:0]  frame_kind;
   logic        frame_end;
   logic [15:0] tag_version;
   logic [1:0]  status;

   modport source (output valid, output out_byte, output out_valid, output frame_kind,
                   output frame_end, output tag_version, output status, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input frame_kind,
                   input frame_end, input tag_version, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/id3_in_stage.sv
// Input register stage: captures one byte item and hands it to the parser.
`default_nettype none

module id3_in_stage
   import id3_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   id3_req_if.sink    req_chan,
   input  wire logic  take,
   output logic       held_valid,
   output logic [7:0] held_byte,
   output logic       held_last
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       accept;

   // Accept while empty or while the held item moves on
   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept)    valid_in = 1'b1;
      else if (take) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   // Hold payload until replaced
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_chan.in_byte;
         last_ff <= req_chan.in_last;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;
   assign held_last  = last_ff;

endmodule

`default_nettype wire

FILE: rtl/id3_parse_core.sv
// Parser core: tag and frame state with the update for one byte.
`default_nettype none

module id3_parse_core
   import id3_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step_en,
   input  wire logic [7:0]              step_byte,
   input  wire logic                    step_last,
   input  wire logic [SELECT_WIDTH-1:0] frame_select,
   output rsp_payload_type              result
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  hc_ff, hc_in;
   logic [27:0] tr_ff, tr_in;
   logic [3:0]  fhc_ff, fhc_in;
   logic [31:0] ident_ff, ident_in;
   logic [31:0] fr_ff, fr_in;
   logic [15:0] version_ff, version_in;
   logic [7:0]  flags_ff, flags_in;
   kind_type    k;
   logic [3:0]  fc_next;
   logic        first;

   // Next state and result for the byte in hand
   always_comb begin
      phase_in   = phase_ff;
      hc_in      = hc_ff;
      tr_in      = tr_ff;
      fhc_in     = fhc_ff;
      ident_in   = ident_ff;
      fr_in      = fr_ff;
      version_in = version_ff;
      flags_in   = flags_ff;
      k          = kind_of(ident_ff);
      fc_next    = fhc_ff + 4'd1;
      first      = (fhc_ff == FHDR_LEN);
      result     = '{out_byte: 8'h00, out_valid: 1'b0, frame_kind: KIND_NONE,
                     frame_end: 1'b0, tag_version: 16'h0000, status: ST_PARSING};

      case (phase_ff)
         PH_HEADER: begin
            // Signature, version, flags, then the synchsafe size
            if (hc_ff < HDR_VERSION_MAJOR) begin
               if (step_byte != sig_byte(hc_ff[1:0])) phase_in = PH_NO_ID3;
            end else if (hc_ff == HDR_VERSION_MAJOR) begin
               version_in = {step_byte, 8'h00};
            end else if (hc_ff == HDR_VERSION_REV) begin
               version_in = {version_ff[15:8], step_byte};
            end else if (hc_ff == HDR_FLAGS) begin
               flags_in = step_byte;
            end else begin
               tr_in = {tr_ff[20:0], step_byte[6:0]};
            end
            if (phase_in == PH_HEADER) begin
               if (hc_ff >= HDR_LAST) begin
                  if (flags_in[EXT_HEADER_BIT]) begin
                     phase_in = PH_ERROR;
                  end else if (tr_in == 28'd0) begin
                     phase_in = PH_TAG_DONE;
                  end else begin
                     phase_in = PH_FRAME_HDR;
                     fhc_in   = 4'd0;
                     ident_in = 32'd0;
                     fr_in    = 32'd0;
                  end
               end else begin
                  hc_in = hc_ff + 4'd1;
               end
            end
         end
         PH_FRAME_HDR: begin
            // Shift in ID and size, skip flag bytes
            tr_in = tr_ff - 28'd1;
            if (fhc_ff < FHDR_ID_END)        ident_in = {ident_ff[23:0], step_byte};
            else if (fhc_ff < FHDR_SIZE_END) fr_in    = {fr_ff[23:0], step_byte};
            fhc_in = fc_next;
            if (fc_next == FHDR_ID_END && ident_in == 32'd0) begin
               phase_in = PH_TAG_DONE;
            end else if (fc_next >= FHDR_LEN) begin
               if (fr_in == 32'd0) begin
                  if (tr_in == 28'd0) begin
                     phase_in = PH_TAG_DONE;
                  end else begin
                     phase_in = PH_FRAME_HDR;
                     fhc_in   = 4'd0;
                     ident_in = 32'd0;
                     fr_in    = 32'd0;
                  end
               end else if (tr_in == 28'd0) begin
                  phase_in = PH_ERROR;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end else if (tr_in == 28'd0) begin
               phase_in = PH_ERROR;
            end
         end
         PH_PAYLOAD: begin
            // Emit payload bytes of selected frames after the encoding byte
            fhc_in = FHDR_IN_PAYLOAD;
            tr_in  = tr_ff - 28'd1;
            fr_in  = fr_ff - 32'd1;
            if (!first && k != KIND_NONE && frame_select[k]) begin
               result.out_byte   = step_byte;
               result.out_valid  = 1'b1;
               result.frame_kind = k;
               result.frame_end  = (fr_in == 32'd0);
            end
            if (fr_in == 32'd0) begin
               if (tr_in == 28'd0) begin
                  phase_in = PH_TAG_DONE;
               end else begin
                  phase_in = PH_FRAME_HDR;
                  fhc_in   = 4'd0;
                  ident_in = 32'd0;
                  fr_in    = 32'd0;
               end
            end else if (tr_in == 28'd0) begin
               phase_in = PH_ERROR;
            end
         end
         default: begin
         end
      endcase

      result.tag_version = version_in;
      case (phase_in)
         PH_NO_ID3:   result.status = ST_NO_ID3;
         PH_TAG_DONE: result.status = ST_DONE;
         PH_ERROR:    result.status = ST_ERROR;
         default:     result.status = step_last ? ST_ERROR : ST_PARSING;
      endcase

      // End of file: start over for the next file
      if (step_last) begin
         phase_in   = PH_HEADER;
         hc_in      = 4'd0;
         tr_in      = 28'd0;
         fhc_in     = 4'd0;
         ident_in   = 32'd0;
         fr_in      = 32'd0;
         version_in = 16'h0000;
         flags_in   = 8'h00;
      end
   end

   // Advance state on each byte taken
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hc_ff      <= 4'd0;
         tr_ff      <= 28'd0;
         fhc_ff     <= 4'd0;
         ident_ff   <= 32'd0;
         fr_ff      <= 32'd0;
         version_ff <= 16'h0000;
         flags_ff   <= 8'h00;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         hc_ff      <= hc_in;
         tr_ff      <= tr_in;
         fhc_ff     <= fhc_in;
         ident_ff   <= ident_in;
         fr_ff      <= fr_in;
         version_ff <= version_in;
         flags_ff   <= flags_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/id3_out_stage.sv
// Result register stage: holds one result item until the receiver takes it.
`default_nettype none

module id3_out_stage
   import id3_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire rsp_payload_type  load_data,
   output logic                  can_load,
   id3_rsp_if.source             rsp_chan
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff;

   // Free when empty or when the held item leaves this cycle
   assign can_load = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load)                valid_in = 1'b1;
      else if (rsp_chan.ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= load_data;
   end

   // Drive the channel from the held item
   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.out_byte    = data_ff.out_byte;
   assign rsp_chan.out_valid   = data_ff.out_valid;
   assign rsp_chan.frame_kind  = data_ff.frame_kind;
   assign rsp_chan.frame_end   = data_ff.frame_end;
   assign rsp_chan.tag_version = data_ff.tag_version;
   assign rsp_chan.status      = data_ff.status;

endmodule

`default_nettype wire

FILE: rtl/id3_tag_frame_extractor_unit.sv
// Top level: ID3v2 tag parser that streams out payload bytes of selected text frames.
//
// Usage:
//  - req_chan carries the file one byte per item (in_byte) with in_last on its final byte.
//  - rsp_chan returns exactly one result item per input item: a payload byte with its
//    frame kind and end marker when a selected frame byte is seen, plus the tag version
//    and the parse status after that byte.
//  - csr_write_enable / csr_write_data load frame_select (one enable bit per kind:
//    title, year, album, artist, bpm); write it only while the block is idle.
//  - Path: an accepted item goes into the input register, then through one pass of parse
//    logic into the result register.
//  - Throughput: one item per cycle while rsp_chan.ready is high; the parse state updates
//    once per byte through counter and compare logic.
//  - Reset: frame_select returns to all kinds enabled, the parser waits for a signature,
//    both stages empty. After a byte with in_last the parser is ready for a new file.
//  - Stall: while rsp_chan.ready is low the result is held, one more item is held in
//    the input register, and req_chan.ready then drops until the result is taken.
`default_nettype none

module id3_tag_frame_extractor_unit
   import id3_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   id3_req_if.sink                      req_chan,
   id3_rsp_if.source                    rsp_chan,
   input  wire logic                    csr_write_enable,
   input  wire logic [SELECT_WIDTH-1:0] csr_write_data
);

   logic [SELECT_WIDTH-1:0] frame_select_ff;
   logic                    held_valid;
   logic [7:0]              held_byte;
   logic                    held_last;
   logic                    can_load;
   logic                    step_en;
   rsp_payload_type         step_result;

   // Frame select register
   always_ff @(posedge clock) begin
      if (reset)                 frame_select_ff <= SELECT_RESET;
      else if (csr_write_enable) frame_select_ff <= csr_write_data;
   end

   // Move the held item through the parser when the result register frees up
   assign step_en = held_valid && can_load;

   id3_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (can_load),
      .held_valid (held_valid),
      .held_byte  (held_byte),
      .held_last  (held_last)
   );

   id3_parse_core u_parse_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .step_byte    (held_byte),
      .step_last    (held_last),
      .frame_select (frame_select_ff),
      .result       (step_result)
   );

   id3_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (step_en),
      .load_data (step_result),
      .can_load  (can_load),
      .rsp_chan  (rsp_chan)
   );

   // A parsed item always lands in the result register
   a_step_lands: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_chan.valid)
      else $error("parsed item did not reach the result register");

   // A full input register with a stalled output must block new items
   a_block_when_full: assert property (@(posedge clock) disable iff (reset)
      (held_valid && !can_load) |-> !req_chan.ready)
      else $error("input accepted while both stages are full");

   // A result without payload carries no kind and no frame end
   a_no_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.out_valid) |->
      (rsp_chan.frame_kind == KIND_NONE && !rsp_chan.frame_end && rsp_chan.out_byte == 8'h00))
      else $error("idle result carries payload fields");

   // A payload byte carries a frame kind
   a_payload_selected: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.out_valid) |->
      (rsp_chan.frame_kind != KIND_NONE))
      else $error("payload byte with no frame kind");

endmodule

`default_nettype wire

FILE: dv/id3_frame_compare.sv
// Result checker: predicts every result item of the ID3 extractor and compares it with the block.
`timescale 1ns / 1ps

module id3_frame_compare
   import id3_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   id3_req_if                      req_mon,
   id3_rsp_if                      rsp_mon,
   input  logic                    csr_write_enable,
   input  logic [SELECT_WIDTH-1:0] csr_write_data,
   output int unsigned             fail_count,
   output int unsigned             pending
);

   // Shadow copy of the parser state and the kind enables
   logic [SELECT_WIDTH-1:0] kind_enable;
   phase_type               parse_phase;
   logic [3:0]              hdr_count;
   logic [27:0]             tag_left;
   logic [3:0]              fhdr_count;
   logic [31:0]             shadow_ident;
   logic [31:0]             frame_left;
   logic [15:0]             version_seen;
   logic [7:0]              hdr_flags;

   rsp_payload_type         expected_items[$];
   rsp_payload_type         oldest;
   rsp_payload_type         predicted;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < 100)
         $display("%0t: mismatch on %s, got 0x%0h, expected 0x%0h", $time, field, got, want);
      fail_count++;
   endtask

   // Map a frame ID to the kind it is reported as
   function automatic kind_type kind_for_id(input logic [31:0] id);
      case (id)
         ID_TITLE:  return KIND_TITLE;
         ID_YEAR:   return KIND_YEAR;
         ID_ALBUM:  return KIND_ALBUM;
         ID_ARTIST: return KIND_ARTIST;
         ID_BPM:    return KIND_BPM;
         default:   return KIND_NONE;
      endcase
   endfunction

   task automatic clear_parser();
      parse_phase  = PH_HEADER;
      hdr_count    = '0;
      tag_left     = '0;
      fhdr_count   = '0;
      shadow_ident = '0;
      frame_left   = '0;
      version_seen = '0;
      hdr_flags    = '0;
   endtask

   task automatic open_frame();
      parse_phase  = PH_FRAME_HDR;
      fhdr_count   = '0;
      shadow_ident = '0;
      frame_left   = '0;
   endtask

   // Advance the shadow parser by one byte and build the result it causes
   task automatic parse_byte(input logic [7:0] b, input logic last,
                             output rsp_payload_type r);
      logic [3:0]  hc;
      logic [7:0]  want;
      int unsigned fc;
      kind_type    k;
      logic        first_byte;
      r            = '0;
      r.frame_kind = KIND_NONE;
      case (parse_phase)
         PH_HEADER: begin
            hc = hdr_count;
            if (hc < 3) begin
               want = 8'(ID3_SIGNATURE >> (8 * (2 - hc)));
               if (b != want) parse_phase = PH_NO_ID3;
            end else if (hc == 3) begin
               version_seen = {b, 8'h00};
            end else if (hc == 4) begin
               version_seen[7:0] = b;
            end else if (hc == 5) begin
               hdr_flags = b;
            end else begin
               tag_left = {tag_left[20:0], b[6:0]};
            end
            if (parse_phase == PH_HEADER) begin
               if (hc >= 9) begin
                  if (hdr_flags[EXT_HEADER_BIT]) parse_phase = PH_ERROR;
                  else if (tag_left == 0) parse_phase = PH_TAG_DONE;
                  else open_frame();
               end else begin
                  hdr_count = hc + 4'd1;
               end
            end
         end
         PH_FRAME_HDR: begin
            fc = fhdr_count;
            tag_left = tag_left - 28'd1;
            if (fc < 4) shadow_ident = {shadow_ident[23:0], b};
            else if (fc < 8) frame_left = {frame_left[23:0], b};
            fc++;
            fhdr_count = 4'(fc);
            if (fc == 4 && shadow_ident == 0) begin
               parse_phase = PH_TAG_DONE;
            end else if (fc >= 10) begin
               if (frame_left == 0) begin
                  if (tag_left == 0) parse_phase = PH_TAG_DONE;
                  else open_frame();
               end else if (tag_left == 0) begin
                  parse_phase = PH_ERROR;
               end else begin
                  parse_phase = PH_PAYLOAD;
               end
            end else if (tag_left == 0) begin
               parse_phase = PH_ERROR;
            end
         end
         PH_PAYLOAD: begin
            k          = kind_for_id(shadow_ident);
            first_byte = (fhdr_count == 4'd10);
            fhdr_count = 4'd11;
            tag_left   = tag_left - 28'd1;
            frame_left = frame_left - 32'd1;
            // Drop the encoding byte; emit the rest of enabled kinds
            if (!first_byte && k != KIND_NONE && kind_enable[k]) begin
               r.out_valid  = 1'b1;
               r.out_byte   = b;
               r.frame_kind = k;
               r.frame_end  = (frame_left == 0);
            end
            if (frame_left == 0) begin
               if (tag_left == 0) parse_phase = PH_TAG_DONE;
               else open_frame();
            end else if (tag_left == 0) begin
               parse_phase = PH_ERROR;
            end
         end
         default: ;
      endcase

      case (parse_phase)
         PH_NO_ID3:   r.status = ST_NO_ID3;
         PH_TAG_DONE: r.status = ST_DONE;
         PH_ERROR:    r.status = ST_ERROR;
         default:     r.status = last ? ST_ERROR : ST_PARSING;
      endcase
      r.tag_version = version_seen;

      // End of file: start over for the next one
      if (last) clear_parser();
   endtask

   // Track accepted items, predict, and compare results in order
   always @(posedge clock) begin
      if (reset) begin
         kind_enable = SELECT_RESET;
         clear_parser();
         expected_items.delete();
      end else begin
         if (csr_write_enable) kind_enable = csr_write_data;
         if (req_mon.valid && req_mon.ready) begin
            parse_byte(req_mon.in_byte, req_mon.in_last, predicted);
            expected_items.push_back(predicted);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_items.size() == 0) begin
               report_mismatch("unexpected item", 32'(rsp_mon.status), 0);
            end else begin
               oldest = expected_items.pop_front();
               if (rsp_mon.out_byte !== oldest.out_byte)
                  report_mismatch("out_byte", 32'(rsp_mon.out_byte), 32'(oldest.out_byte));
               if (rsp_mon.out_valid !== oldest.out_valid)
                  report_mismatch("out_valid", 32'(rsp_mon.out_valid), 32'(oldest.out_valid));
               if (rsp_mon.frame_kind !== oldest.frame_kind)
                  report_mismatch("frame_kind", 32'(rsp_mon.frame_kind), 32'(oldest.frame_kind));
               if (rsp_mon.frame_end !== oldest.frame_end)
                  report_mismatch("frame_end", 32'(rsp_mon.frame_end), 32'(oldest.frame_end));
               if (rsp_mon.tag_version !== oldest.tag_version)
                  report_mismatch("tag_version", 32'(rsp_mon.tag_version),
                                  32'(oldest.tag_version));
               if (rsp_mon.status !== oldest.status)
                  report_mismatch("status", 32'(rsp_mon.status), 32'(oldest.status));
            end
         end
      end
      pending = expected_items.size();
   end

endmodule

FILE: dv/testbench.sv
// Testbench top: drives files of bytes into the ID3 extractor and gives the verdict.
`timescale 1ns / 1ps

module testbench;
   import id3_pkg::*;

   localparam int unsigned HOLD_CYCLES  = 40;
   localparam int unsigned PHASE_BYTES  = 360;

   logic                    clock;
   logic                    reset;
   logic                    csr_write_enable;
   logic [SELECT_WIDTH-1:0] csr_write_data;

   id3_req_if req_chan ();
   id3_rsp_if rsp_chan ();

   int unsigned fail_count;
   int unsigned pending;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned holds_asked;
   int unsigned bytes_sent;

   logic [7:0] file_bytes[$];
   logic [7:0] tag_body[$];

   id3_tag_frame_extractor_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   id3_frame_compare u_compare (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop for a hung run
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Result side: random back-pressure, plus long hold-offs on request
   initial begin : recv_side
      int unsigned holds_done;
      holds_done     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done != holds_asked) begin
            holds_done++;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Offer one item and hold it until it is taken; returns on a falling edge
   task automatic offer_byte(input logic [7:0] value, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= value;
      req_chan.in_last <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering and wait for every outstanding result
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_select(input logic [SELECT_WIDTH-1:0] value);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_file();
      int unsigned i;
      for (i = 0; i < file_bytes.size(); i++)
         offer_byte(file_bytes[i], i == file_bytes.size() - 1);
      bytes_sent += file_bytes.size();
   endtask

   task automatic push_word(input logic [31:0] w);
      tag_body.push_back(w[31:24]);
      tag_body.push_back(w[23:16]);
      tag_body.push_back(w[15:8]);
      tag_body.push_back(w[7:0]);
   endtask

   // Build a tag with random frames; now and then break it
   task automatic build_tag_file();
      int unsigned n_frames;
      int unsigned fsize;
      int unsigned tag_size;
      int unsigned pick;
      int unsigned n;
      int unsigned k;
      logic [31:0] fid;
      logic [7:0]  flags;
      tag_body.delete();
      n_frames = $urandom_range(1, 5);
      repeat (n_frames) begin
         pick = $urandom_range(0, 6);
         case (pick)
            0:       fid = ID_TITLE;
            1:       fid = ID_YEAR;
            2:       fid = ID_ALBUM;
            3:       fid = ID_ARTIST;
            4:       fid = ID_BPM;
            default: fid = $urandom;
         endcase
         pick = $urandom_range(0, 19);
         if (pick < 2) fsize = 0;
         else if (pick < 18) fsize = $urandom_range(1, 10);
         else fsize = $urandom;
         push_word(fid);
         push_word(fsize);
         tag_body.push_back(8'($urandom));
         tag_body.push_back(8'($urandom));
         n = (fsize <= 10) ? fsize : $urandom_range(0, 8);
         repeat (n) tag_body.push_back(8'($urandom));
      end
      // Pad with zeros now and then
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 4)) tag_body.push_back(8'h00);

      // Size field: mostly exact, sometimes short, long or zero
      tag_size = tag_body.size();
      pick = $urandom_range(0, 9);
      if (pick == 0) tag_size = tag_size - $urandom_range(1, tag_size - 1);
      else if (pick == 1) tag_size = tag_size + $urandom_range(1, 6);
      else if (pick == 2 && $urandom_range(0, 2) == 0) tag_size = 0;

      flags = 8'($urandom);
      if ($urandom_range(0, 11) != 0) flags[EXT_HEADER_BIT] = 1'b0;

      file_bytes.delete();
      file_bytes.push_back(ID3_SIGNATURE[23:16]);
      file_bytes.push_back(ID3_SIGNATURE[15:8]);
      file_bytes.push_back(ID3_SIGNATURE[7:0]);
      file_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h03);
      file_bytes.push_back(8'($urandom));
      file_bytes.push_back(flags);
      for (k = 0; k < 4; k++)
         file_bytes.push_back({($urandom_range(0, 7) == 0), 7'(tag_size >> (7 * (3 - k)))});
      foreach (tag_body[i]) file_bytes.push_back(tag_body[i]);
      // Audio data after the tag
      repeat ($urandom_range(0, 5)) file_bytes.push_back(8'($urandom));

      if ($urandom_range(0, 14) == 0) file_bytes[$urandom_range(0, 2)] = 8'($urandom);
      // Cut the file short now and then
      if ($urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, file_bytes.size() - 1);
         while (file_bytes.size() > n) void'(file_bytes.pop_back());
      end
   endtask

   // Short run of random bytes, often starting like a signature
   task automatic build_noise_file();
      int unsigned n;
      n = $urandom_range(1, 12);
      file_bytes.delete();
      repeat (n) file_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 1)) file_bytes[0] = ID3_SIGNATURE[23:16];
      if (n > 1 && $urandom_range(0, 1)) file_bytes[1] = ID3_SIGNATURE[15:8];
   endtask

   initial begin : stimulus
      int unsigned ph;
      int unsigned n_files;
      int unsigned target;
      int unsigned pick;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = '0;
      req_chan.in_last = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      send_idle_pct    = 25;
      recv_idle_pct    = 73;
      holds_asked      = 0;
      bytes_sent       = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty tag: done right after the header
      file_bytes = {8'h49, 8'h44, 8'h33, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_file();
      // Extended header flag with all-ones bytes elsewhere
      file_bytes = {8'h49, 8'h44, 8'h33, 8'hFF, 8'hFF, 8'h40, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_file();
      // Bad signature, then a file ending inside the signature
      file_bytes = {8'h49, 8'h00};
      send_file();
      file_bytes = {8'h49};
      send_file();

      // Random files in three idling patterns
      for (ph = 0; ph < 3; ph++) begin
         wait_idle();
         send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 73 : 0;
         recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 25 : 0;
         write_select((ph == 0) ? 5'h1F : (ph == 1) ? 5'h00 : 5'($urandom));
         n_files = 0;
         target  = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            if (n_files % 5 == 4) begin
               wait_idle();
               write_select(5'($urandom));
            end
            pick = $urandom_range(0, 9);
            // Stall the result side while a full tag keeps coming
            if (ph == 2 && n_files == 1) begin
               holds_asked++;
               pick = 0;
            end
            if (pick < 8) build_tag_file();
            else build_noise_file();
            send_file();
            n_files++;
         end
      end

      wait_idle();
      repeat (8) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/id3_pkg.sv
rtl/id3_req_if.sv
rtl/id3_rsp_if.sv
rtl/id3_in_stage.sv
rtl/id3_parse_core.sv
rtl/id3_out_stage.sv
rtl/id3_tag_frame_extractor_unit.sv
dv/id3_frame_compare.sv
dv/testbench.sv
